FILE: hdl/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPS_CHECK_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WPS_CHECK_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/wps_pkg.sv
`default_nettype none
package wps_pkg;

	localparam int MAX_PAGES_DEF = 1024;
	localparam int SLOTS_DEF     = 10;
	localparam int VAL_W         = 16;
	localparam int MASK_W        = 10;
	localparam int IDX_W         = 10;
	localparam int TOTAL_W       = 11;

	localparam logic [1:0] OP_WRITE_PAGE  = 2'd0;
	localparam logic [1:0] OP_WRITE_QUERY = 2'd1;
	localparam logic [1:0] OP_SET_CURRENT = 2'd2;
	localparam logic [1:0] OP_SEARCH      = 2'd3;

	typedef struct packed {
		logic accept;
		logic start;
		logic scan;
		logic restart;
		logic record_hit;
		logic retry_hit;
		logic post;
	} ctl_cmd_t;

	typedef struct packed {
		logic hit;
		logic pass_end;
		logic retry_req;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

FILE: hdl/wps_ram.sv
`default_nettype none
module wps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: hdl/wps_datapath.sv
`default_nettype none
module wps_datapath #(
	parameter int MAX_PAGES = wps_pkg::MAX_PAGES_DEF,
	parameter int SLOTS     = wps_pkg::SLOTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire wps_pkg::ctl_cmd_t            cmd,
	output wps_pkg::dp_sts_t                  sts,
	input  wire logic                         cfg_we,
	input  wire logic [wps_pkg::TOTAL_W-1:0]  cfg_data,
	input  wire logic [1:0]                   operation,
	input  wire logic [9:0]                   entry_index,
	input  wire logic [3:0]                   slot_index,
	input  wire logic signed [15:0]           slot_value,
	input  wire logic [3:0]                   field_count,
	input  wire logic [9:0]                   wildcard_mask,
	input  wire logic                         negate_retry,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              found,
	output logic [9:0]                        hit_index,
	output logic                              hit_on_retry
);

	localparam int PW = $clog2(MAX_PAGES);
	localparam int TW = PW + 1;
	localparam int CW = (TW > wps_pkg::TOTAL_W) ? TW : wps_pkg::TOTAL_W;
	localparam int EW = (TW > 10) ? TW : 10;
	localparam int IW = wps_pkg::IDX_W;
	localparam int VW = wps_pkg::VAL_W;

	logic [TW-1:0]    total_q;
	logic [PW-1:0]    cur_q;
	logic [VW-1:0]    query_q [SLOTS];
	logic [SLOTS-1:0] en_q;
	logic             retry_q;
	logic [PW-1:0]    ptr_q;
	logic [TW-1:0]    remain_q;
	logic             v_s1;
	logic [PW-1:0]    idx_s1;
	logic             res_found_q;
	logic [PW-1:0]    res_idx_q;
	logic             res_retry_q;
	logic             out_valid_q;
	logic             out_found_q;
	logic [IW-1:0]    out_idx_q;
	logic             out_retry_q;

	logic [CW-1:0]    cfg_ext;
	logic [CW-1:0]    cfg_sat;
	logic [EW-1:0]    entry_ext;
	logic             entry_ok;
	logic [TW-1:0]    after_cur;
	logic [PW-1:0]    start_ptr;
	logic [TW-1:0]    wrap_pg;
	logic [SLOTS-1:0] wild;
	logic [SLOTS-1:0] en_next;
	logic [SLOTS-1:0] slot_ok;
	logic [VW-1:0]    rd [SLOTS];
	logic             match;

	// A page total of zero counts as one page; above the table size it saturates.
	always_comb begin
		cfg_ext = CW'(cfg_data);
		if (cfg_ext == '0) begin
			cfg_sat = CW'(1);
		end else if (cfg_ext > CW'(MAX_PAGES)) begin
			cfg_sat = CW'(MAX_PAGES);
		end else begin
			cfg_sat = cfg_ext;
		end
	end

	assign entry_ext = EW'(entry_index);
	assign entry_ok  = entry_ext < EW'(MAX_PAGES);

	// The scan visits exactly page_total pages, starting after the current page
	// and wrapping to page 0 after the last one.
	assign after_cur = TW'(cur_q) + TW'(1);
	assign start_ptr = (after_cur < total_q) ? PW'(after_cur) : '0;
	assign wrap_pg   = total_q - TW'(1);

	for (genvar g = 0; g < SLOTS; g++) begin : g_lane
		if (g < wps_pkg::MASK_W) begin : g_wild
			assign wild[g] = wildcard_mask[g];
		end else begin : g_nowild
			assign wild[g] = 1'b0;
		end
		assign en_next[g] = (5'(g) < {1'b0, field_count}) && !wild[g];

		wps_ram #(
			.WIDTH(VW),
			.DEPTH(MAX_PAGES)
		) u_ram (
			.clk  (clk),
			.we   (cmd.accept && operation == wps_pkg::OP_WRITE_PAGE && entry_ok
				&& slot_index == 4'(g)),
			.waddr(PW'(entry_ext)),
			.wdata(slot_value),
			.raddr(ptr_q),
			.rdata(rd[g])
		);

		assign slot_ok[g] = (rd[g] == query_q[g]) || !en_q[g];
	end

	assign match = v_s1 && (&slot_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TW'(1);
			cur_q   <= '0;
			for (int s = 0; s < SLOTS; s++) begin
				query_q[s] <= '0;
			end
		end else begin
			if (cfg_we) begin
				total_q <= TW'(cfg_sat);
			end
			if (cmd.accept && operation == wps_pkg::OP_SET_CURRENT && entry_ok) begin
				cur_q <= PW'(entry_ext);
			end
			for (int s = 0; s < SLOTS; s++) begin
				if (cmd.accept && operation == wps_pkg::OP_WRITE_QUERY
						&& slot_index == 4'(s)) begin
					query_q[s] <= slot_value;
				end
			end
			// The negated first query slot is kept after the retry pass.
			if (cmd.restart) begin
				query_q[0] <= -query_q[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			en_q    <= en_next;
			retry_q <= negate_retry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			remain_q <= '0;
			v_s1     <= 1'b0;
			idx_s1   <= '0;
		end else if (cmd.start || cmd.restart) begin
			ptr_q    <= start_ptr;
			remain_q <= total_q;
			v_s1     <= 1'b0;
		end else if (cmd.scan && remain_q != '0) begin
			v_s1     <= 1'b1;
			idx_s1   <= ptr_q;
			ptr_q    <= (TW'(ptr_q) == wrap_pg) ? '0 : ptr_q + PW'(1);
			remain_q <= remain_q - TW'(1);
		end else begin
			v_s1     <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_found_q <= 1'b0;
			res_idx_q   <= '0;
			res_retry_q <= 1'b0;
		end else if (cmd.accept) begin
			res_found_q <= 1'b0;
			res_idx_q   <= '0;
			res_retry_q <= 1'b0;
		end else if (cmd.record_hit) begin
			res_found_q <= 1'b1;
			res_idx_q   <= idx_s1;
			res_retry_q <= cmd.retry_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.post) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			out_found_q <= res_found_q;
			out_idx_q   <= IW'(res_idx_q);
			out_retry_q <= res_retry_q;
		end
	end

	assign sts.hit       = match;
	assign sts.pass_end  = (remain_q == '0) && !v_s1;
	assign sts.retry_req = retry_q;
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign found        = out_found_q;
	assign hit_index    = out_idx_q;
	assign hit_on_retry = out_retry_q;

endmodule
`default_nettype wire

FILE: hdl/wps_ctrl.sv
`default_nettype none
module wps_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [1:0]        operation,
	output logic                   in_stall,
	output wps_pkg::ctl_cmd_t      cmd,
	input  wire wps_pkg::dp_sts_t  sts
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_RETRY = 4'b0100,
		S_POST  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_next;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (operation == wps_pkg::OP_SEARCH) begin
						cmd.start  = 1'b1;
						state_next = S_SCAN;
					end else begin
						state_next = S_POST;
					end
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					cmd.record_hit = 1'b1;
					state_next     = S_POST;
				end else if (sts.pass_end) begin
					if (sts.retry_req) begin
						cmd.restart = 1'b1;
						state_next  = S_RETRY;
					end else begin
						state_next = S_POST;
					end
				end
			end
			S_RETRY: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					cmd.record_hit = 1'b1;
					cmd.retry_hit  = 1'b1;
					state_next     = S_POST;
				end else if (sts.pass_end) begin
					state_next = S_POST;
				end
			end
			S_POST: begin
				if (sts.out_free) begin
					cmd.post   = 1'b1;
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule
`default_nettype wire

FILE: hdl/wildcard_page_search_top.sv
`default_nettype none
// Wildcard page search. Items write one slot of a page, write one query slot,
// set the current page, or search; every item returns exactly one result.
// A search reads one page per cycle from the slot memories, all slot compares of a
// page in parallel. With negate_retry set, a search that misses on its first pass
// makes a second pass. The scan stops at the first hit. A stalled result holds the
// next finished item back. One item is in work at a time; the finished result
// waits in the output register while the next item is taken. Page contents are
// undefined until written, and the page store is not cleared after reset. The
// configuration port is always ready and must only be written while no item is
// in work.
module wildcard_page_search_top #(
	parameter int MAX_PAGES = wps_pkg::MAX_PAGES_DEF,
	parameter int SLOTS     = wps_pkg::SLOTS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [wps_pkg::TOTAL_W-1:0] page_total,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [1:0]                  operation,
	input  wire logic [9:0]                  entry_index,
	input  wire logic [3:0]                  slot_index,
	input  wire logic signed [15:0]          slot_value,
	input  wire logic [3:0]                  field_count,
	input  wire logic [9:0]                  wildcard_mask,
	input  wire logic                        negate_retry,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             found,
	output logic [9:0]                       hit_index,
	output logic                             hit_on_retry
);

	wps_pkg::ctl_cmd_t cmd;
	wps_pkg::dp_sts_t  sts;

	assign cfg_ready = 1'b1;

	wps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.operation(operation),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	wps_datapath #(
		.MAX_PAGES(MAX_PAGES),
		.SLOTS    (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (page_total),
		.operation    (operation),
		.entry_index  (entry_index),
		.slot_index   (slot_index),
		.slot_value   (slot_value),
		.field_count  (field_count),
		.wildcard_mask(wildcard_mask),
		.negate_retry (negate_retry),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.hit_index    (hit_index),
		.hit_on_retry (hit_on_retry)
	);

endmodule
`default_nettype wire

FILE: hdl/wps_checker.sv
`default_nettype none
`include "assert_macros.svh"
module wps_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       found,
	input wire logic [9:0] hit_index,
	input wire logic       hit_on_retry
);

	// A miss reports index zero and never claims a retry hit.
	`WPS_CHECK_NOW(a_miss_clean, clk, arst_n, out_valid && !found, hit_index == '0 && !hit_on_retry, "miss result carries hit data")

	`WPS_CHECK_NOW(a_retry_found, clk, arst_n, out_valid && hit_on_retry, found, "retry hit without found")

	// Only one item is in work at a time, so an accepted item closes the input.
	`WPS_CHECK_NEXT(a_busy_after, clk, arst_n, in_valid && !in_stall, in_stall, "input open right after an accepted item")

	`WPS_CHECK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(found) && $stable(hit_index) && $stable(hit_on_retry), "stalled result changed")

endmodule

bind wildcard_page_search_top wps_checker u_wps_checker (.*);
`default_nettype wire
